// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Clocked next-cycle implication check, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lvm_pkg.sv -----
// Shared types, constants and codes of the looping voice mixer.
package lvm_pkg;

  localparam int MAX_VOICES = 8;
  localparam int NUM_CLIPS  = 32;
  localparam int CLIP_DEPTH = 16384;

  localparam int VIDX_W  = $clog2(MAX_VOICES);
  localparam int CNT_W   = $clog2(MAX_VOICES + 1);
  localparam int CLIP_W  = 5;
  localparam int CADDR_W = $clog2(CLIP_DEPTH);
  localparam int SADDR_W = $clog2(NUM_CLIPS) + CADDR_W;
  localparam int POS_W   = 15;
  localparam int GAIN_W  = 9;
  localparam int EV_W    = 16;

  localparam int DVD_W = 19;
  localparam int DSR_W = 4;

  localparam logic [2:0] M_LOAD  = 3'd0;
  localparam logic [2:0] M_LEN   = 3'd1;
  localparam logic [2:0] M_EVENT = 3'd2;
  localparam logic [2:0] M_END   = 3'd3;
  localparam logic [2:0] M_MIX   = 3'd4;

  localparam logic [2:0] R_DIVISOR  = 3'd0;
  localparam logic [2:0] R_ALCOHOL  = 3'd1;
  localparam logic [2:0] R_CRITICAL = 3'd2;
  localparam logic [2:0] R_FASTMASK = 3'd3;
  localparam logic [2:0] R_BLOCKLEN = 3'd4;

  localparam logic [1:0] FX_NONE     = 2'd0;
  localparam logic [1:0] FX_SLOW     = 2'd1;
  localparam logic [1:0] FX_FAST     = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [EV_W-1:0]     event_id;
    logic [CLIP_W-1:0]   clip;
    logic [GAIN_W-1:0]   gain;
    logic [POS_W-1:0]    pos;
    logic                refr;
  } voice_t;

  typedef struct packed {
    logic   shift;
    logic   load;
    voice_t load_data;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/lvm_voice_cell.sv -----
// One voice slot of the rotating voice chain.
module lvm_voice_cell
  import lvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  voice_t     d_in,
  output voice_t     q
);

  voice_t voice_r;
  voice_t voice_nxt;

  always_comb begin
    voice_nxt = voice_r;
    if (ctrl.load) begin
      voice_nxt = ctrl.load_data;
    end else if (ctrl.shift) begin
      voice_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_r <= '0;
    end else begin
      voice_r <= voice_nxt;
    end
  end

  assign q = voice_r;

endmodule

// ----- hw/rtl/lvm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lvm_div
  import lvm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int ITER_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DSR_W:0]   rem_r, rem_nxt;
  logic [DSR_W:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r[DSR_W-1:0], dvd_r[DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sh - {1'b0, dsr_r};
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == ITER_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- hw/rtl/looping_voice_mixer_top.sv -----
// Top level of the looping voice mixer: voice ring, clip store, mixer and control.
// Clip-word and clip-length words go straight to the settling state S_FIN. For voice
// events and end-of-update words, the eight voice slots form a ring that rotates
// once, one voice past the shared head logic per cycle, then the settling state
// registers the result once the output register is free. A mix word passes the
// eight-step rotation, the clip-store read and multiply registers, the divider
// start, the divider's 19 one-bit-per-cycle steps for the attenuation divisor and
// its completion flag, then the settling state. No clearing pass is needed
// after reset. A new word is taken whenever the block is idle, even while the
// previous result still waits in the output register.
`include "assert_macros.svh"

module looping_voice_mixer_top
  import lvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [15:0]        in_event_id,
  input  logic [4:0]         in_clip_number,
  input  logic [8:0]         in_distance,
  input  logic [14:0]        in_clip_address,
  input  logic signed [15:0] in_clip_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic [3:0]         out_active_voices,
  output logic [1:0]         out_effect_state,
  output logic               out_event_dropped,
  output logic               out_clipped
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROT   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam int ACC_W  = 28;
  localparam int PROD_W = 26;

  logic [3:0]  divisor_r;
  logic [4:0]  alcohol_r, critical_r;
  logic [31:0] fastmask_r;
  logic [12:0] blocklen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r  <= 4'd7;
      alcohol_r  <= 5'd10;
      critical_r <= 5'd12;
      fastmask_r <= '0;
      blocklen_r <= 13'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        R_DIVISOR:  divisor_r  <= cfg_data[3:0];
        R_ALCOHOL:  alcohol_r  <= cfg_data[4:0];
        R_CRITICAL: critical_r <= cfg_data[4:0];
        R_FASTMASK: fastmask_r <= cfg_data;
        R_BLOCKLEN: blocklen_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic [2:0]        state_r, state_nxt;
  logic [VIDX_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]        mode_r;
  logic [EV_W-1:0]   ev_r;
  logic [CLIP_W-1:0] clip_r;
  logic [GAIN_W-1:0] gain_r;
  logic              found_r, found_nxt;
  logic              free_r, free_nxt;
  logic [VIDX_W-1:0] free_idx_r, free_idx_nxt;
  logic              alc_r, alc_nxt, crit_r, crit_nxt;
  logic [1:0]        effect_r;
  logic [11:0]       frame_r;
  logic [POS_W-1:0]  len_r [NUM_CLIPS];

  logic in_acc, fin_go;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign fin_go   = (state_r == S_FIN) && (!out_valid || out_ready);

  voice_t     cell_q [MAX_VOICES];
  voice_t     cell_d [MAX_VOICES];
  cell_ctrl_t cell_ctrl [MAX_VOICES];
  voice_t     hd, hd_upd, new_voice;
  logic       insert;

  assign hd        = cell_q[0];
  assign insert    = fin_go && (mode_r == M_EVENT) && !found_r && free_r;
  assign new_voice = '{valid: 1'b1, event_id: ev_r, clip: clip_r, gain: gain_r,
                       pos: '0, refr: 1'b1};

  genvar gi;
  generate
    for (gi = 0; gi < MAX_VOICES; gi++) begin : g_cell
      if (gi == MAX_VOICES - 1) begin : g_tail
        assign cell_d[gi] = hd_upd;
      end else begin : g_mid
        assign cell_d[gi] = cell_q[gi + 1];
      end
      assign cell_ctrl[gi] = '{shift: (state_r == S_ROT),
                               load: insert && (free_idx_r == VIDX_W'(gi)),
                               load_data: new_voice};
      lvm_voice_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cell_ctrl[gi]),
        .d_in  (cell_d[gi]),
        .q     (cell_q[gi])
      );
    end
  endgenerate

  logic [POS_W-1:0] hd_len;
  logic [1:0]       step;
  logic [POS_W:0]   p_sum, p_wrap;
  logic             contrib;

  assign hd_len  = len_r[hd.clip];
  assign contrib = hd.valid && (hd.pos < hd_len);

  always_comb begin
    if (effect_r == FX_SLOW) begin
      step = (hd.clip == alcohol_r || frame_r[0]) ? 2'd1 : 2'd0;
    end else if (effect_r == FX_FAST) begin
      step = fastmask_r[hd.clip] ? 2'd2 : 2'd1;
    end else begin
      step = 2'd1;
    end
    p_sum  = {1'b0, hd.pos} + {{(POS_W-1){1'b0}}, step};
    p_wrap = p_sum;
    if (p_sum >= {1'b0, hd_len}) begin
      p_wrap = p_sum - {1'b0, hd_len};
      if (p_wrap >= {1'b0, hd_len}) begin
        p_wrap = '0;
      end
    end
  end

  always_comb begin
    hd_upd       = hd;
    found_nxt    = found_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    alc_nxt      = alc_r;
    crit_nxt     = crit_r;
    if (in_acc) begin
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
      alc_nxt   = 1'b0;
      crit_nxt  = 1'b0;
    end
    if (state_r == S_ROT) begin
      case (mode_r)
        M_EVENT: begin
          if (hd.valid && hd.event_id == ev_r) begin
            hd_upd.gain = gain_r;
            hd_upd.refr = 1'b1;
            found_nxt   = 1'b1;
          end
          if (!hd.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cnt_r;
          end
        end
        M_END: begin
          hd_upd.valid = hd.valid && hd.refr;
          hd_upd.refr  = 1'b0;
          if (hd.valid && hd.refr) begin
            if (hd.clip == alcohol_r) alc_nxt = 1'b1;
            if (hd.clip == critical_r) crit_nxt = 1'b1;
          end
        end
        M_MIX: begin
          if (hd.valid) begin
            hd_upd.pos = p_wrap[POS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  logic signed [15:0] store_r [NUM_CLIPS * CLIP_DEPTH];
  logic signed [15:0] rdata_r;
  logic [SADDR_W-1:0] raddr;
  logic               store_we;

  assign raddr    = {hd.clip, hd.pos[CADDR_W-1:0]};
  assign store_we = in_acc && (in_mode == M_LOAD) && (in_clip_address < POS_W'(CLIP_DEPTH));

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[{in_clip_number, in_clip_address[CADDR_W-1:0]}] <= in_clip_word;
    end
    rdata_r <= store_r[raddr];
  end

  logic                     contrib_s1;
  logic [GAIN_W-1:0]        gain_s1;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]         acc_mag;
  logic                     neg_r;
  logic                     div_done;
  logic [DVD_W-1:0]         quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrib_s1 <= 1'b0;
      prod_r     <= '0;
      acc_r      <= '0;
    end else begin
      contrib_s1 <= (state_r == S_ROT) && (mode_r == M_MIX) && contrib;
      prod_r     <= contrib_s1 ? PROD_W'(rdata_r * $signed({1'b0, gain_s1})) : '0;
      if (in_acc) begin
        acc_r <= '0;
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    gain_s1 <= hd.gain;
  end

  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;

  always_ff @(posedge clk) begin
    if (state_r == S_DIVGO) begin
      neg_r <= acc_r[ACC_W-1];
    end
  end

  lvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIVGO),
    .dividend (acc_mag[DVD_W+7:8]),
    .divisor  ((divisor_r == 4'd0) ? 4'd1 : divisor_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          if (in_mode == M_EVENT || in_mode == M_END || in_mode == M_MIX) begin
            state_nxt = S_ROT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_ROT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == VIDX_W'(MAX_VOICES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (mode_r == M_MIX) ? S_DRAIN : S_FIN;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[0]) begin
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [8:0]  in_gain;
  logic [12:0] blen;
  logic [12:0] frame_inc;
  logic [1:0]  effect_nxt;
  logic [CNT_W-1:0] nvalid;
  logic signed [15:0] mixed;
  logic               clip_flag;

  assign in_gain   = in_distance[8] ? 9'd0 : 9'd256 - in_distance;
  assign blen      = (blocklen_r == 13'd0) ? 13'd1 :
                     (blocklen_r > 13'd4096) ? 13'd4096 : blocklen_r;
  assign frame_inc = {1'b0, frame_r} + 13'd1;
  assign effect_nxt = (mode_r == M_END) ? (alc_r ? FX_SLOW : (crit_r ? FX_FAST : FX_NONE))
                                        : effect_r;

  always_comb begin
    nvalid = '0;
    for (int i = 0; i < MAX_VOICES; i++) begin
      nvalid = nvalid + CNT_W'(cell_q[i].valid);
    end
    nvalid = nvalid + CNT_W'(insert);
  end

  always_comb begin
    mixed     = '0;
    clip_flag = 1'b0;
    if (mode_r == M_MIX) begin
      if (!neg_r) begin
        if (quot > DVD_W'(32767)) begin
          mixed     = 16'sh7fff;
          clip_flag = 1'b1;
        end else begin
          mixed = $signed(quot[15:0]);
        end
      end else begin
        if (quot > DVD_W'(32768)) begin
          mixed     = 16'sh8000;
          clip_flag = 1'b1;
        end else begin
          mixed = $signed(16'(-quot[15:0]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      alc_r     <= 1'b0;
      crit_r    <= 1'b0;
      effect_r  <= FX_NONE;
      frame_r   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CLIPS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      free_r  <= free_nxt;
      alc_r   <= alc_nxt;
      crit_r  <= crit_nxt;
      if (in_acc) begin
        if (in_mode == M_LEN) begin
          len_r[in_clip_number] <= (in_clip_address > POS_W'(CLIP_DEPTH)) ?
                                   POS_W'(CLIP_DEPTH) : in_clip_address;
        end
      end
      if (fin_go) begin
        effect_r <= effect_nxt;
        if (mode_r == M_MIX) begin
          frame_r <= (frame_inc >= blen) ? 12'd0 : frame_inc[11:0];
        end
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    free_idx_r <= free_idx_nxt;
    if (in_acc) begin
      mode_r <= in_mode;
      ev_r   <= in_event_id;
      clip_r <= in_clip_number;
      gain_r <= in_gain;
    end
    if (fin_go) begin
      out_sample        <= mixed;
      out_active_voices <= 4'(nvalid);
      out_effect_state  <= effect_nxt;
      out_event_dropped <= (mode_r == M_EVENT) && !found_r && !free_r;
      out_clipped       <= clip_flag;
    end
  end

  `ASSERT_IMPLIES(a_clip_rails, out_valid && out_clipped,
    out_sample == 16'sh7fff || out_sample == 16'sh8000,
    "saturated word is not at a rail")
  `ASSERT_IMPLIES(a_drop_full, out_valid && out_event_dropped,
    out_active_voices == 4'(MAX_VOICES), "event dropped while a slot was free")
  `ASSERT_NEXT(a_div_wait, state_r == S_DIVGO, state_r == S_DIVW && !in_ready,
    "divider start not followed by the wait state")

endmodule
